@@ design/pneg_pkg.sv @@
package pneg_pkg;

   localparam int FreqW  = 18;
   localparam int NoteW  = 7;
   localparam int VelW   = 7;
   localparam int AgeW   = 16;
   localparam int RptW   = 8;
   localparam int CsrIdxW = 3;
   localparam int CsrDataW = 16;

   localparam int TabLen = 129;
   localparam int CntW   = 8;

   localparam logic [NoteW-1:0] VelOn = 7'd70;
   localparam logic [NoteW-1:0] PrevNoteReset = 7'd1;

   localparam logic [CsrIdxW-1:0] RegGateEnable = 3'd0;
   localparam logic [CsrIdxW-1:0] RegMinNote    = 3'd1;
   localparam logic [CsrIdxW-1:0] RegMaxNote    = 3'd2;
   localparam logic [CsrIdxW-1:0] RegRepeatAllow = 3'd3;
   localparam logic [CsrIdxW-1:0] RegRepeatWrap = 3'd4;
   localparam logic [CsrIdxW-1:0] RegGateMs     = 3'd5;
   localparam logic [CsrIdxW-1:0] RegSustainMs  = 3'd6;

   // Entry j is the smallest frequency code whose note number is at least j.
   localparam logic [FreqW-1:0] BoundTab [0:TabLen-1] = '{
      18'd124, 18'd131, 18'd139, 18'd147, 18'd156, 18'd165, 18'd175, 18'd185,
      18'd196, 18'd208, 18'd221, 18'd234, 18'd247, 18'd262, 18'd278, 18'd294,
      18'd312, 18'd330, 18'd350, 18'd370, 18'd392, 18'd416, 18'd440, 18'd467,
      18'd494, 18'd524, 18'd555, 18'd588, 18'd623, 18'd660, 18'd699, 18'd740,
      18'd784, 18'd831, 18'd880, 18'd933, 18'd988, 18'd1047, 18'd1109, 18'd1175,
      18'd1245, 18'd1319, 18'd1397, 18'd1480, 18'd1568, 18'd1662, 18'd1760,
      18'd1865, 18'd1976, 18'd2094, 18'd2218, 18'd2350, 18'd2490, 18'd2638,
      18'd2794, 18'd2960, 18'd3136, 18'd3323, 18'd3520, 18'd3730, 18'd3952,
      18'd4187, 18'd4435, 18'd4699, 18'd4979, 18'd5275, 18'd5588, 18'd5920,
      18'd6272, 18'd6645, 18'd7459, 18'd7903, 18'd8373, 18'd8870, 18'd9398,
      18'd9957, 18'd10549, 18'd11176, 18'd11840, 18'd12544, 18'd13290,
      18'd14080, 18'd14918, 18'd15805, 18'd16745, 18'd17740, 18'd18795,
      18'd19913, 18'd21097, 18'd22351, 18'd23680, 18'd25088, 18'd26580,
      18'd28160, 18'd29835, 18'd31609, 18'd33489, 18'd35480, 18'd37590,
      18'd39825, 18'd42193, 18'd44702, 18'd47360, 18'd50176, 18'd53159,
      18'd56320, 18'd59669, 18'd63218, 18'd66977, 18'd70959, 18'd75179,
      18'd79649, 18'd84385, 18'd89403, 18'd94719, 18'd100351, 18'd106318,
      18'd112640, 18'd119338, 18'd126435, 18'd133953, 18'd141918, 18'd150357,
      18'd159297, 18'd168770, 18'd178805, 18'd189438, 18'd200702, 18'd212636
   };

   typedef struct packed {
      logic             note_on;
      logic [NoteW-1:0] note;
      logic [VelW-1:0]  velocity;
      logic             last;
   } event_type;

   // Number of table entries that the code reaches. The code is compared with every entry at
   // once; the table rises, so the compares form a thermometer code that is encoded here.
   // Zero means below the lowest note, TabLen means above the highest note.
   function automatic logic [CntW-1:0] bound_count(input logic [FreqW-1:0] code);
      logic [TabLen+1:0] reach;
      logic [CntW-1:0]   cnt;
      reach[0]        = 1'b1;
      reach[TabLen+1] = 1'b0;
      for (int j = 1; j <= TabLen; j++) begin
         reach[j] = (code >= BoundTab[j-1]);
      end
      cnt = '0;
      for (int j = 0; j <= TabLen; j++) begin
         if (reach[j] && !reach[j+1]) begin
            cnt = cnt | CntW'(j);
         end
      end
      return cnt;
   endfunction

endpackage

@@ design/pneg_req_if.sv @@
interface pneg_req_if;
   logic                       valid;
   logic                       ready;
   logic                       kind;
   logic [pneg_pkg::FreqW-1:0] freq;

   modport source (output valid, kind, freq, input ready);
   modport sink (input valid, kind, freq, output ready);
endinterface

@@ design/pneg_rsp_if.sv @@
interface pneg_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       note_on;
   logic [pneg_pkg::NoteW-1:0] note;
   logic [pneg_pkg::VelW-1:0]  velocity;
   logic                       last;

   modport source (output valid, note_on, note, velocity, last, input ready);
   modport sink (input valid, note_on, note, velocity, last, output ready);
endinterface

@@ design/pitch_to_note_event_gate.sv @@
// Pitch-to-note event gate. Each request is a one-millisecond tick or a detected pitch; a
// pitch is turned into a note number by comparing it with every entry of a constant boundary
// table in parallel, filtered by the note range and the repeat counter, and may release the
// held note (note-off, velocity 0) and then start a new one (note-on, velocity 70) once the
// gate interval has passed. The block has a three-stage pipeline: input register, note lookup
// register and the state update, which writes up to two events into a four-entry result
// buffer. A request is taken in every cycle while the buffer holds two entries or fewer and
// passes the input and note lookup registers before the state update writes its events.
// Events leave at one per cycle while the receiver is ready, so throughput is one request per
// cycle for requests that cause at most one event. The flag last marks a request's final event.
module pitch_to_note_event_gate (
   input  logic                          clock,
   input  logic                          reset,
   pneg_req_if.sink                      req_ch,
   pneg_rsp_if.source                    rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [pneg_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [pneg_pkg::CsrDataW-1:0] csr_wdata
);
   import pneg_pkg::*;

   logic             gate_enable_ff;
   logic [NoteW-1:0] min_note_ff;
   logic [NoteW-1:0] max_note_ff;
   logic [RptW-1:0]  repeat_allow_ff;
   logic [RptW-1:0]  repeat_wrap_ff;
   logic [AgeW-1:0]  gate_ms_ff;
   logic [AgeW-1:0]  sustain_ms_ff;

   logic             s1_valid_ff, s1_valid_in;
   logic             s1_kind_ff;
   logic [FreqW-1:0] s1_freq_ff;
   logic             s2_valid_ff, s2_valid_in;
   logic             s2_kind_ff;
   logic             s2_range_ff;
   logic [NoteW-1:0] s2_note_ff;
   logic [CntW-1:0]  s1_count;

   logic             slot_valid_ff, slot_valid_in;
   logic [NoteW-1:0] slot_note_ff, slot_note_in;
   logic [AgeW-1:0]  note_age_ff, note_age_in;
   logic [AgeW-1:0]  gate_elapsed_ff, gate_elapsed_in;
   logic [NoteW-1:0] prev_note_ff, prev_note_in;
   logic [RptW-1:0]  repeat_count_ff, repeat_count_in;

   event_type        buf_ff [0:3];
   logic [1:0]       rd_ptr_ff, rd_ptr_in;
   logic [1:0]       wr_ptr_ff, wr_ptr_in;
   logic [2:0]       cnt_ff, cnt_in;

   logic             advance;
   logic             pop;
   logic [1:0]       n_push;
   event_type        ev_a, ev_b;
   logic             pass;
   logic             rel;
   logic             take;
   logic [RptW-1:0]  rc_inc;
   logic [RptW-1:0]  rc_new;

   assign advance      = (cnt_ff <= 3'd2);
   assign req_ch.ready = advance;
   assign pop          = rsp_ch.valid && rsp_ch.ready;

   assign rsp_ch.valid    = (cnt_ff != 3'd0);
   assign rsp_ch.note_on  = buf_ff[rd_ptr_ff].note_on;
   assign rsp_ch.note     = buf_ff[rd_ptr_ff].note;
   assign rsp_ch.velocity = buf_ff[rd_ptr_ff].velocity;
   assign rsp_ch.last     = buf_ff[rd_ptr_ff].last;

   assign s1_count = bound_count(s1_freq_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_enable_ff  <= 1'b1;
         min_note_ff     <= 7'd0;
         max_note_ff     <= 7'd127;
         repeat_allow_ff <= 8'd0;
         repeat_wrap_ff  <= 8'd50;
         gate_ms_ff      <= 16'd500;
         sustain_ms_ff   <= 16'd1000;
      end else if (csr_wr_en) begin
         case (csr_index)
            RegGateEnable: begin
               gate_enable_ff <= csr_wdata[0];
            end
            RegMinNote: begin
               min_note_ff <= csr_wdata[NoteW-1:0];
            end
            RegMaxNote: begin
               max_note_ff <= csr_wdata[NoteW-1:0];
            end
            RegRepeatAllow: begin
               repeat_allow_ff <= csr_wdata[RptW-1:0];
            end
            RegRepeatWrap: begin
               repeat_wrap_ff <= csr_wdata[RptW-1:0];
            end
            RegGateMs: begin
               gate_ms_ff <= csr_wdata[AgeW-1:0];
            end
            RegSustainMs: begin
               sustain_ms_ff <= csr_wdata[AgeW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s2_valid_in = s2_valid_ff;
      if (advance) begin
         s1_valid_in = req_ch.valid;
         s2_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_kind_ff  <= req_ch.kind;
         s1_freq_ff  <= req_ch.freq;
         s2_kind_ff  <= s1_kind_ff;
         s2_range_ff <= (s1_count != CntW'(0)) && (s1_count != CntW'(TabLen));
         s2_note_ff  <= NoteW'(s1_count - CntW'(1));
      end
   end

   always_comb begin
      slot_valid_in   = slot_valid_ff;
      slot_note_in    = slot_note_ff;
      note_age_in     = note_age_ff;
      gate_elapsed_in = gate_elapsed_ff;
      prev_note_in    = prev_note_ff;
      repeat_count_in = repeat_count_ff;
      pass   = 1'b0;
      rel    = 1'b0;
      take   = 1'b0;
      rc_inc = (repeat_count_ff == 8'hFF) ? repeat_count_ff : repeat_count_ff + 8'd1;
      rc_new = (rc_inc > repeat_wrap_ff) ? 8'd0 : rc_inc;
      n_push = 2'd0;
      ev_a   = '0;
      ev_b   = '0;
      if (advance && s2_valid_ff) begin
         if (!s2_kind_ff) begin
            if (note_age_ff != 16'hFFFF) begin
               note_age_in = note_age_ff + 16'd1;
            end
            if (gate_elapsed_ff != 16'hFFFF) begin
               gate_elapsed_in = gate_elapsed_ff + 16'd1;
            end
         end else if (gate_enable_ff && s2_range_ff && s2_note_ff >= min_note_ff
                      && s2_note_ff <= max_note_ff) begin
            pass = 1'b1;
            if (prev_note_ff == s2_note_ff) begin
               repeat_count_in = rc_new;
               if (rc_new > repeat_allow_ff) begin
                  pass = 1'b0;
               end
            end
         end
         if (pass) begin
            rel  = slot_valid_ff && (note_age_ff > sustain_ms_ff);
            take = (gate_elapsed_ff > gate_ms_ff) && (!slot_valid_ff || rel);
            if (rel) begin
               slot_valid_in = 1'b0;
               slot_note_in  = '0;
               note_age_in   = '0;
            end
            if (gate_elapsed_ff > gate_ms_ff) begin
               gate_elapsed_in = '0;
            end
            if (take) begin
               slot_valid_in = 1'b1;
               slot_note_in  = s2_note_ff;
               note_age_in   = '0;
               prev_note_in  = s2_note_ff;
            end
            if (rel && take) begin
               ev_a   = '{note_on: 1'b0, note: slot_note_ff, velocity: '0, last: 1'b0};
               ev_b   = '{note_on: 1'b1, note: s2_note_ff, velocity: VelOn, last: 1'b1};
               n_push = 2'd2;
            end else if (rel) begin
               ev_a   = '{note_on: 1'b0, note: slot_note_ff, velocity: '0, last: 1'b1};
               n_push = 2'd1;
            end else if (take) begin
               ev_a   = '{note_on: 1'b1, note: s2_note_ff, velocity: VelOn, last: 1'b1};
               n_push = 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff   <= 1'b0;
         slot_note_ff    <= '0;
         note_age_ff     <= '0;
         gate_elapsed_ff <= '0;
         prev_note_ff    <= PrevNoteReset;
         repeat_count_ff <= '0;
      end else begin
         slot_valid_ff   <= slot_valid_in;
         slot_note_ff    <= slot_note_in;
         note_age_ff     <= note_age_in;
         gate_elapsed_ff <= gate_elapsed_in;
         prev_note_ff    <= prev_note_in;
         repeat_count_ff <= repeat_count_in;
      end
   end

   always_comb begin
      rd_ptr_in = pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff + n_push;
      cnt_in    = cnt_ff + {1'b0, n_push} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         buf_ff[wr_ptr_ff] <= ev_a;
      end
      if (n_push == 2'd2) begin
         buf_ff[wr_ptr_ff + 2'd1] <= ev_b;
      end
   end

endmodule

@@ bench/pitch_to_note_event_gate_test.sv @@
`timescale 1ns / 100ps

module pitch_to_note_event_gate_test;
   import pneg_pkg::*;

   localparam int HalfPeriod = 5;
   localparam int ResetCycles = 8;
   localparam int QuietLimit = 3000;
   localparam int SettleCycles = 8;
   localparam int EndDrain = 20;
   localparam int MaxGap = 30;
   localparam int LongHold = 300;
   localparam int MaxReports = 10;

   localparam logic KindTick  = 1'b0;
   localparam logic KindPitch = 1'b1;
   localparam logic [CsrIdxW-1:0] RegUnused = 3'd7;

   class gate_mirror;
      logic             gate_en;
      logic [NoteW-1:0] lo_note, hi_note;
      logic [RptW-1:0]  rpt_allow, rpt_wrap;
      logic [AgeW-1:0]  gate_ms, hold_ms;
      logic             held;
      logic [NoteW-1:0] held_note, prev_note;
      logic [AgeW-1:0]  age, since_gate;
      logic [RptW-1:0]  rpt;
      event_type        due_events[$];
      int               errors;

      function void clear();
         gate_en = 1'b1;
         lo_note = '0;
         hi_note = 7'd127;
         rpt_allow = '0;
         rpt_wrap = 8'd50;
         gate_ms = 16'd500;
         hold_ms = 16'd1000;
         held = 1'b0;
         held_note = '0;
         prev_note = PrevNoteReset;
         age = '0;
         since_gate = '0;
         rpt = '0;
         due_events.delete();
         errors = 0;
      endfunction

      function void write_reg(logic [CsrIdxW-1:0] idx, logic [CsrDataW-1:0] val);
         case (idx)
            RegGateEnable:  gate_en = val[0];
            RegMinNote:     lo_note = val[NoteW-1:0];
            RegMaxNote:     hi_note = val[NoteW-1:0];
            RegRepeatAllow: rpt_allow = val[RptW-1:0];
            RegRepeatWrap:  rpt_wrap = val[RptW-1:0];
            RegGateMs:      gate_ms = val[AgeW-1:0];
            RegSustainMs:   hold_ms = val[AgeW-1:0];
            default: ;
         endcase
      endfunction

      function void take_request(logic kind, logic [FreqW-1:0] code);
         int n;
         int cnt;
         logic [NoteW-1:0] nt;
         event_type evs[2];
         if (kind == KindTick) begin
            if (age != '1) age++;
            if (since_gate != '1) since_gate++;
            return;
         end
         if (!gate_en) return;
         n = -1;
         for (int i = 0; i < TabLen; i++)
            if (code >= BoundTab[i]) n = i;
         if (n < 0 || n > 127) return;
         nt = n[NoteW-1:0];
         if (nt < lo_note || nt > hi_note) return;
         if (nt == prev_note) begin
            if (rpt != '1) rpt++;
            if (rpt > rpt_wrap) rpt = '0;
            if (rpt > rpt_allow) return;
         end
         cnt = 0;
         if (held && age > hold_ms) begin
            evs[cnt] = '{note_on: 1'b0, note: held_note, velocity: '0, last: 1'b0};
            cnt++;
            held = 1'b0;
            held_note = '0;
            age = '0;
         end
         if (since_gate > gate_ms) begin
            if (!held) begin
               held = 1'b1;
               held_note = nt;
               age = '0;
               prev_note = nt;
               evs[cnt] = '{note_on: 1'b1, note: nt, velocity: VelOn, last: 1'b0};
               cnt++;
            end
            since_gate = '0;
         end
         if (cnt > 0) evs[cnt-1].last = 1'b1;
         for (int i = 0; i < cnt; i++) due_events.push_back(evs[i]);
      endfunction

      function void check_event(event_type got);
         event_type want;
         if (due_events.size() == 0) begin
            errors++;
            if (errors <= MaxReports)
               $display("unexpected event: on=%0d note=%0d vel=%0d last=%0d",
                        got.note_on, got.note, got.velocity, got.last);
            return;
         end
         want = due_events.pop_front();
         if (got.note_on !== want.note_on || got.note !== want.note ||
             got.velocity !== want.velocity || got.last !== want.last) begin
            errors++;
            if (errors <= MaxReports)
               $display({"event mismatch: expected on=%0d note=%0d vel=%0d last=%0d, ",
                         "actual on=%0d note=%0d vel=%0d last=%0d"},
                        want.note_on, want.note, want.velocity, want.last,
                        got.note_on, got.note, got.velocity, got.last);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CsrIdxW-1:0] csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   pneg_req_if req_if();
   pneg_rsp_if rsp_if();

   pitch_to_note_event_gate dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   gate_mirror book;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_len;
   int hold_id;
   int hold_seen = 0;
   int hold_left = 0;
   int quiet = 0;
   int sent_items;
   int cur_lo, cur_hi, cur_gate;
   int last_note;

   initial clock = 1'b0;
   always #(HalfPeriod) clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         book.check_event('{note_on: rsp_if.note_on, note: rsp_if.note,
                            velocity: rsp_if.velocity, last: rsp_if.last});
      if (hold_id != hold_seen) begin
         hold_seen = hold_id;
         hold_left = hold_len;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
      if (quiet >= QuietLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic logic [FreqW-1:0] freq_for_note(int n);
      int lo_code, hi_code;
      if (n < 0) begin
         lo_code = 0;
         hi_code = BoundTab[0] - 1;
      end else if (n >= TabLen - 1) begin
         lo_code = BoundTab[TabLen-1];
         hi_code = (1 << FreqW) - 1;
      end else begin
         lo_code = BoundTab[n];
         hi_code = BoundTab[n+1] - 1;
      end
      case ($urandom_range(2))
         0: return FreqW'(lo_code);
         1: return FreqW'(hi_code);
         default: return FreqW'($urandom_range(hi_code, lo_code));
      endcase
   endfunction

   task automatic send_item(input logic kind, input logic [FreqW-1:0] code);
      int gap;
      gap = 0;
      while (gap < MaxGap && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.kind <= kind;
      req_if.freq <= code;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      book.take_request(kind, code);
      sent_items++;
   endtask

   task automatic send_tick();
      send_item(KindTick, FreqW'($urandom));
   endtask

   task automatic send_note(input int n);
      send_item(KindPitch, freq_for_note(n));
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      while (book.due_events.size() > 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_settings(input int en, input int lo, input int hi, input int allow,
                                 input int wrap, input int gms, input int sms);
      logic [CsrIdxW-1:0] idx [8];
      int vals [8];
      int widths [8];
      logic [CsrDataW-1:0] mask;
      logic [CsrDataW-1:0] data;
      idx = '{RegGateEnable, RegMinNote, RegMaxNote, RegRepeatAllow, RegRepeatWrap,
              RegGateMs, RegSustainMs, RegUnused};
      vals = '{en, lo, hi, allow, wrap, gms, sms, 0};
      widths = '{1, NoteW, NoteW, RptW, RptW, AgeW, AgeW, 0};
      for (int i = 0; i < 8; i++) begin
         mask = CsrDataW'((32'd1 << widths[i]) - 1);
         data = (CsrDataW'($urandom) & ~mask) | (CsrDataW'(vals[i]) & mask);
         csr_wr_en <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= data;
         book.write_reg(idx[i], data);
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      cur_lo = lo;
      cur_hi = hi;
      cur_gate = gms;
   endtask

   task automatic random_phase(input int count);
      int start;
      int r;
      int n;
      start = sent_items;
      while (sent_items - start < count) begin
         r = $urandom_range(99);
         if (r < 80) begin
            repeat ($urandom_range(cur_gate + 2)) send_tick();
            if ($urandom_range(3) == 0) n = last_note;
            else if (cur_lo <= cur_hi && $urandom_range(1) == 0)
               n = $urandom_range(cur_hi, cur_lo);
            else n = $urandom_range(127);
            last_note = n;
            send_note(n);
         end else if (r < 90) begin
            send_note($urandom_range(1) ? -1 : TabLen - 1);
         end else begin
            send_item(1'($urandom), FreqW'($urandom));
         end
      end
   endtask

   task automatic set_idle_mode(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
         default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
   endtask

   initial begin
      int lo, hi;
      book = new();
      book.clear();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_len = 0;
      hold_id = 0;
      sent_items = 0;
      last_note = 0;
      cur_lo = 0;
      cur_hi = 127;
      cur_gate = 500;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_if.valid <= 1'b0;
      req_if.kind <= KindTick;
      req_if.freq <= '0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      send_tick();
      send_note(60);
      settle();

      write_settings(1, 0, 127, 0, 50, 0, 0);
      send_tick();
      send_item(KindPitch, '0);
      send_item(KindPitch, '1);
      send_item(KindPitch, BoundTab[0] - 1);
      send_item(KindPitch, BoundTab[0]);
      send_tick();
      send_item(KindPitch, BoundTab[TabLen-1] - 1);
      send_tick();
      send_item(KindPitch, BoundTab[TabLen-1] - 1);
      send_note(60);
      send_tick();
      send_note(60);
      send_tick();
      send_item(KindPitch, BoundTab[TabLen-1]);
      settle();

      write_settings(0, 0, 127, 0, 50, 0, 0);
      send_tick();
      send_note(70);
      settle();

      write_settings(1, 40, 40, 0, 50, 0, 0);
      send_tick();
      send_note(39);
      send_note(41);
      send_note(40);
      settle();

      // The receiver holds off while the sender keeps offering, so the block backs up.
      write_settings(1, 0, 127, 0, 50, 0, 0);
      hold_len = LongHold;
      hold_id++;
      random_phase(150);
      settle();

      // Repeated top note with the widest repeat limits drives the repeat count to saturation.
      set_idle_mode(2);
      write_settings(1, 127, 127, 255, 255, 0, 0);
      send_tick();
      repeat (270) begin
         if ($urandom_range(3) == 0) send_tick();
         send_note(127);
      end
      settle();

      set_idle_mode(3);
      write_settings(1, 0, 0, 0, 0, 1, 2);
      random_phase(100);
      settle();

      set_idle_mode(1);
      write_settings(1, 90, 30, 1, 2, 0, 1);
      random_phase(60);
      settle();

      for (int p = 0; p < 10; p++) begin
         set_idle_mode(p % 4);
         if ($urandom_range(1) == 0) begin
            lo = 0;
            hi = 127;
         end else begin
            lo = $urandom_range(100);
            hi = $urandom_range(127, lo);
         end
         write_settings(($urandom_range(5) != 0), lo, hi,
                        ($urandom_range(4) == 0) ? 255 : $urandom_range(4),
                        ($urandom_range(4) == 0) ? 255 : $urandom_range(6),
                        $urandom_range(6), $urandom_range(10));
         random_phase(120);
         settle();
      end

      req_if.valid <= 1'b0;
      while (book.due_events.size() > 0) @(posedge clock);
      repeat (EndDrain) @(posedge clock);
      if (book.errors == 0 && book.due_events.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/pneg_pkg.sv
design/pneg_req_if.sv
design/pneg_rsp_if.sv
design/pitch_to_note_event_gate.sv
bench/pitch_to_note_event_gate_test.sv
